FILE: src/mandelbrot_escape_test_assert.svh
// Assertion macros shared by the escape-time tester RTL.
`ifndef MANDELBROT_ESCAPE_TEST_ASSERT_SVH
`define MANDELBROT_ESCAPE_TEST_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define MET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication, disabled while reset is held.
`define MET_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/met_pkg.sv
// Package with the types and constants of the escape-time tester.
package met_pkg;

  localparam int unsigned FracBits  = 28;
  localparam int unsigned DataW     = 32;
  localparam int unsigned ZW        = DataW + 2;
  localparam int unsigned MagW      = FracBits + 1;
  localparam int unsigned SqW       = FracBits + 2;
  localparam int unsigned MulAW     = DataW + 1;
  localparam int unsigned MulPW     = MulAW + DataW;
  localparam int unsigned VtxShift  = 17;
  localparam int unsigned MaxIterW  = 11;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic signed [ZW-1:0] ZTwo  = ZW'(2 ** (FracBits + 1));
  localparam logic [SqW:0]          SqFour = (SqW + 1)'(2 ** (FracBits + 2));

  localparam logic [CfgIdxW-1:0] RegMaxIter  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOffsetRe = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOffsetIm = 2'd2;
  localparam logic [CfgIdxW-1:0] RegZoom     = 2'd3;

  localparam logic [MaxIterW-1:0] ResetMaxIter  = 11'd10;
  localparam logic [DataW-1:0]    ResetOffsetRe = 32'd496605594;
  localparam logic [DataW-1:0]    ResetOffsetIm = 32'd0;
  localparam logic [DataW-1:0]    ResetZoom     = 32'd16085;

  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StSqRe = 9'b000000010,
    StSqIm = 9'b000000100,
    StCross = 9'b000001000,
    StUpdIm = 9'b000010000,
    StVtxX = 9'b000100000,
    StVtxY = 9'b001000000,
    StVtxSat = 9'b010000000,
    StOut = 9'b100000000
  } state_e;

  // Shift a product magnitude right, apply the sign and saturate to 32 bits.
  function automatic logic [DataW-1:0] vtx_sat(input logic [MulPW-1:0] prod,
                                                input logic neg);
    logic [MulPW-VtxShift-1:0] m;
    logic [DataW-1:0] res;
    m = prod[MulPW-1:VtxShift];
    if (!neg) begin
      if (|m[MulPW-VtxShift-1:DataW-1]) begin
        res = {1'b0, {(DataW-1){1'b1}}};
      end else begin
        res = m[DataW-1:0];
      end
    end else begin
      if ((|m[MulPW-VtxShift-1:DataW]) || (m[DataW-1] && (|m[DataW-2:0]))) begin
        res = {1'b1, {(DataW-1){1'b0}}};
      end else begin
        res = DataW'(0) - m[DataW-1:0];
      end
    end
    return res;
  endfunction

endpackage

FILE: src/mandelbrot_escape_test.sv
// Mandelbrot escape-time tester with a shared multiplier and a small sequencer.
//
// Channel   Direction  Request content
// s_axis    in         tdata = c_re, c_im
// m_axis    out        tdata = point_x, point_y; tuser = in_set
// cfg       in         cfg_index_i selects the register, cfg_data_i holds the value
//
// A bounded point runs through StSqRe, StSqIm, StCross and StUpdIm on each iteration, through
// StSqRe for the final limit check and through StVtxX, StVtxY and StVtxSat on the vertex, then
// offers its result in StOut until it is taken.
// An escaped point skips the vertex and offers its result right after the failing test.
// The input is not ready until the result has been taken on m_axis, which may stall.
// Reset idles the sequencer, clears the vertex history and reloads the config defaults.
`include "mandelbrot_escape_test_assert.svh"

module mandelbrot_escape_test #(
  parameter int unsigned ITER_LIMIT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [2*met_pkg::DataW-1:0]       s_axis_tdata,  // c_re, c_im
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [2*met_pkg::DataW-1:0]       m_axis_tdata,  // point_x, point_y
  output logic                              m_axis_tuser,  // in_set
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [met_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [met_pkg::DataW-1:0]         cfg_data_i
);
  import met_pkg::*;

  localparam int unsigned IterW = $clog2(ITER_LIMIT + 1);
  localparam int unsigned CmpW  = (IterW > MaxIterW) ? IterW : MaxIterW;

  state_e state_q, state_d;

  logic [MaxIterW-1:0]     max_iter_q;
  logic signed [DataW-1:0] offset_re_q, offset_im_q;
  logic [DataW-1:0]        zoom_q;
  logic signed [DataW-1:0] c_re_q, c_im_q;
  logic signed [ZW-1:0]    z_re_q, z_im_q;
  logic [SqW-1:0]          sq_re_q, sq_im_q, cross_q;
  logic                    cross_neg_q;
  logic [IterW-1:0]        iter_q, iter_lim_q;
  logic [MulPW-1:0]        prod_q;
  logic                    vneg_q;
  logic [DataW-1:0]        last_x_q, last_y_q;
  logic                    in_set_q;

  logic [MulAW-1:0]        mul_a;
  logic [DataW-1:0]        mul_b;
  logic [MulPW-1:0]        mul_p;
  logic [ZW-1:0]           z_re_abs, z_im_abs;
  logic                    z_big;
  logic [SqW:0]            sq_sum;
  logic signed [DataW:0]   sum_x, sum_y;
  logic [DataW:0]          sum_x_abs, sum_y_abs;
  logic [SqW-1:0]          sq_slice;
  logic signed [SqW:0]     cross_s;
  logic [CmpW-1:0]         lim_cmp;

  assign z_re_abs = z_re_q[ZW-1] ? (ZW'(0) - z_re_q) : z_re_q;
  assign z_im_abs = z_im_q[ZW-1] ? (ZW'(0) - z_im_q) : z_im_q;
  assign z_big = (z_re_q >= ZTwo) || (z_re_q <= -ZTwo) ||
                 (z_im_q >= ZTwo) || (z_im_q <= -ZTwo);
  assign sq_sum = {1'b0, sq_re_q} + {1'b0, sq_im_q};
  assign sum_x = {c_re_q[DataW-1], c_re_q} + {offset_re_q[DataW-1], offset_re_q};
  assign sum_y = {c_im_q[DataW-1], c_im_q} + {offset_im_q[DataW-1], offset_im_q};
  assign sum_x_abs = sum_x[DataW] ? ((DataW + 1)'(0) - sum_x) : sum_x;
  assign sum_y_abs = sum_y[DataW] ? ((DataW + 1)'(0) - sum_y) : sum_y;
  assign cross_s = cross_neg_q ? ((SqW + 1)'(0) - {1'b0, cross_q}) : {1'b0, cross_q};
  assign lim_cmp = (CmpW'(max_iter_q) > CmpW'(ITER_LIMIT)) ? CmpW'(ITER_LIMIT)
                                                           : CmpW'(max_iter_q);

  // Shared multiplier with operand selection by sequencer state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StSqRe: begin
        mul_a = MulAW'(z_re_abs[MagW-1:0]);
        mul_b = DataW'(z_re_abs[MagW-1:0]);
      end
      StSqIm: begin
        mul_a = MulAW'(z_im_abs[MagW-1:0]);
        mul_b = DataW'(z_im_abs[MagW-1:0]);
      end
      StCross: begin
        mul_a = MulAW'(z_re_abs[MagW-1:0]);
        mul_b = DataW'(z_im_abs[MagW-1:0]);
      end
      StVtxX: begin
        mul_a = sum_x_abs;
        mul_b = zoom_q;
      end
      StVtxY: begin
        mul_a = sum_y_abs;
        mul_b = zoom_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = MulPW'(mul_a) * MulPW'(mul_b);
  assign sq_slice = mul_p[FracBits+SqW-1:FracBits];

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          state_d = StSqRe;
        end
      end
      StSqRe: begin
        if (iter_q == iter_lim_q) begin
          state_d = StVtxX;
        end else if (z_big) begin
          state_d = StOut;
        end else begin
          state_d = StSqIm;
        end
      end
      StSqIm: begin
        state_d = StCross;
      end
      StCross: begin
        if (sq_sum >= SqFour) begin
          state_d = StOut;
        end else begin
          state_d = StUpdIm;
        end
      end
      StUpdIm: begin
        state_d = StSqRe;
      end
      StVtxX: begin
        state_d = StVtxY;
      end
      StVtxY: begin
        state_d = StVtxSat;
      end
      StVtxSat: begin
        state_d = StOut;
      end
      StOut: begin
        if (m_axis_tready) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      max_iter_q  <= ResetMaxIter;
      offset_re_q <= ResetOffsetRe;
      offset_im_q <= ResetOffsetIm;
      zoom_q      <= ResetZoom;
      last_x_q    <= '0;
      last_y_q    <= '0;
      in_set_q    <= 1'b0;
      iter_q      <= '0;
      iter_lim_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegMaxIter:  max_iter_q  <= cfg_data_i[MaxIterW-1:0];
          RegOffsetRe: offset_re_q <= cfg_data_i;
          RegOffsetIm: offset_im_q <= cfg_data_i;
          RegZoom:     zoom_q      <= cfg_data_i;
          default: begin
          end
        endcase
      end
      case (state_q)
        StIdle: begin
          iter_q     <= '0;
          iter_lim_q <= lim_cmp[IterW-1:0];
        end
        StSqRe: begin
          if (iter_q == iter_lim_q) begin
            in_set_q <= 1'b1;
          end else if (z_big) begin
            in_set_q <= 1'b0;
          end
        end
        StCross: begin
          if (sq_sum >= SqFour) begin
            in_set_q <= 1'b0;
          end
        end
        StUpdIm: begin
          iter_q <= iter_q + IterW'(1);
        end
        StVtxY: begin
          last_x_q <= vtx_sat(prod_q, vneg_q);
        end
        StVtxSat: begin
          last_y_q <= vtx_sat(prod_q, vneg_q);
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          c_re_q <= s_axis_tdata[DataW-1:0];
          c_im_q <= s_axis_tdata[2*DataW-1:DataW];
          z_re_q <= {{2{s_axis_tdata[DataW-1]}}, s_axis_tdata[DataW-1:0]};
          z_im_q <= {{2{s_axis_tdata[2*DataW-1]}}, s_axis_tdata[2*DataW-1:DataW]};
        end
      end
      StSqRe: begin
        sq_re_q <= sq_slice;
      end
      StSqIm: begin
        sq_im_q <= sq_slice;
      end
      StCross: begin
        cross_q     <= sq_slice;
        cross_neg_q <= z_re_q[ZW-1] ^ z_im_q[ZW-1];
        z_re_q      <= ZW'(sq_re_q) - ZW'(sq_im_q) + {{2{c_re_q[DataW-1]}}, c_re_q};
      end
      StUpdIm: begin
        z_im_q <= {{(ZW-SqW-2){cross_s[SqW]}}, cross_s, 1'b0} +
                  {{2{c_im_q[DataW-1]}}, c_im_q};
      end
      StVtxX: begin
        prod_q <= mul_p;
        vneg_q <= sum_x[DataW];
      end
      StVtxY: begin
        prod_q <= mul_p;
        vneg_q <= sum_y[DataW];
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {last_y_q, last_x_q};
  assign m_axis_tuser  = in_set_q;
  assign cfg_ready_o   = 1'b1;

  `MET_ASSERT(a_no_overlap, !(s_axis_tready && m_axis_tvalid),
              "input ready while a result is pending")
  `MET_ASSERT_IMPL(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                   "input still ready after a point was accepted")
  `MET_ASSERT(a_iter_bound, iter_q <= iter_lim_q, "iteration count passed its limit")
  `MET_ASSERT_IMPL(a_escape_out, (state_q == StSqRe) && (iter_q != iter_lim_q) && z_big,
                   m_axis_tvalid && !m_axis_tuser,
                   "large component did not give an escaped result")

endmodule
